>>> src/apm_pkg.sv
// Package for the ADC power and RMS meter: widths, register indexes,
// reset values and the gain scaling saturation function.
// No dependencies.
`timescale 1ns / 1ps

package apm_pkg;

  localparam int ADC_BITS = 12;
  localparam int SMP_W    = 12;
  localparam int GAIN_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int LEN_W    = 16;
  localparam int OUT_W    = 20;
  localparam int POW_W    = 2 * OUT_W;
  localparam int SUM_W    = 56;
  localparam int ACC_W    = ADC_BITS + GAIN_W;
  localparam int SCL_W    = ACC_W - FRAC_W;
  localparam int CMP_W    = (SCL_W > OUT_W) ? SCL_W : OUT_W;
  localparam int CNT_W    = $clog2(SUM_W);
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_VOLTAGE_GAIN  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CURRENT_GAIN  = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

  localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST  = 24'd264055;
  localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST  = 24'd52813;
  localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RST = 16'd100;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Drop the fraction bits and clamp to the output range.
  function automatic logic [OUT_W-1:0] sat_scale(input logic [ACC_W-1:0] acc);
    logic [CMP_W-1:0] q;
    q = CMP_W'(acc[ACC_W-1:FRAC_W]);
    if (q > CMP_W'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return OUT_W'(q);
  endfunction

endpackage

>>> src/adc_power_rms_meter_unit.sv
// Top level of the ADC power and RMS meter: bit-serial gain scaling,
// power and square products, window accumulation, divide and square root.
// Depends on apm_pkg.
`timescale 1ns / 1ps

// One request carries a voltage and a current ADC sample and yields one
// result. Scaling works through the ADC_BITS (12) sample bits and the
// power and square products through the 20 bits of the scaled current,
// one bit per cycle on shift-and-add units; a hand-off state then passes
// the result on. A request that closes an RMS window adds a restoring
// divide of the 56-bit square sum by the window length and a 20-step
// digit-by-digit square root. The next request is taken once the result
// sits in the output register, even while it still waits to be taken.
module adc_power_rms_meter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [apm_pkg::SMP_W-1:0]         in_voltage_sample,
  input  logic [apm_pkg::SMP_W-1:0]         in_current_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [apm_pkg::OUT_W-1:0]         out_voltage_mv,
  output logic [apm_pkg::OUT_W-1:0]         out_current_ma,
  output logic [apm_pkg::POW_W-1:0]         out_power_uw,
  output logic [apm_pkg::OUT_W-1:0]         out_rms_ma,
  output logic                              out_rms_valid,
  input  logic                              cfg_we,
  input  logic [apm_pkg::IDX_W-1:0]         cfg_index,
  input  logic [apm_pkg::GAIN_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MULT,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t state_r;

  logic [apm_pkg::GAIN_W-1:0]   vgain_r, cgain_r;
  logic [apm_pkg::LEN_W-1:0]    len_r;
  logic [apm_pkg::LEN_W-1:0]    win_cnt_r;
  logic [apm_pkg::SUM_W-1:0]    sq_sum_r;
  logic [apm_pkg::CNT_W-1:0]    step_r;

  logic [apm_pkg::ADC_BITS-1:0] vs_r, cs_r;
  logic [apm_pkg::ACC_W-1:0]    acc_v_r, acc_c_r;
  logic [apm_pkg::OUT_W-1:0]    vmv_r, cma_r, mq_r;
  logic [apm_pkg::POW_W-1:0]    pow_r, sq_r;
  logic [apm_pkg::LEN_W-1:0]    dv_rem_r;
  logic [apm_pkg::SUM_W-1:0]    dq_r;
  logic [apm_pkg::POW_W-1:0]    rad_r;
  logic [apm_pkg::OUT_W:0]      srem_r;
  logic [apm_pkg::OUT_W-1:0]    root_r;
  logic                         rmsv_r;

  logic                         out_valid_r;
  logic [apm_pkg::OUT_W-1:0]    out_vmv_r, out_cma_r, out_rms_r;
  logic [apm_pkg::POW_W-1:0]    out_pow_r;
  logic                         out_rmsv_r;

  logic [apm_pkg::LEN_W-1:0]    len_eff;
  logic [apm_pkg::ACC_W-1:0]    acc_v_nxt, acc_c_nxt;
  logic [apm_pkg::POW_W-1:0]    pow_nxt, sq_nxt;
  logic [apm_pkg::SUM_W-1:0]    sum_add;
  logic [apm_pkg::LEN_W-1:0]    cnt_inc;
  logic                         win_close;
  logic [apm_pkg::LEN_W:0]      div_sh;
  logic                         div_ge;
  logic [apm_pkg::LEN_W-1:0]    dv_rem_nxt;
  logic [apm_pkg::SUM_W-1:0]    dq_nxt;
  logic [apm_pkg::POW_W-1:0]    rad_ld;
  logic [apm_pkg::OUT_W+2:0]    sq_cur, sq_trial;
  logic                         sq_ge;
  logic [apm_pkg::OUT_W:0]      srem_nxt;
  logic [apm_pkg::OUT_W-1:0]    root_nxt;
  logic                         step_last;

  always_comb begin
    len_eff   = (len_r == '0) ? apm_pkg::LEN_W'(1) : len_r;
    step_last = (step_r == '0);

    acc_v_nxt = {acc_v_r[apm_pkg::ACC_W-2:0], 1'b0}
              + (vs_r[apm_pkg::ADC_BITS-1] ? apm_pkg::ACC_W'(vgain_r) : '0);
    acc_c_nxt = {acc_c_r[apm_pkg::ACC_W-2:0], 1'b0}
              + (cs_r[apm_pkg::ADC_BITS-1] ? apm_pkg::ACC_W'(cgain_r) : '0);

    pow_nxt = {pow_r[apm_pkg::POW_W-2:0], 1'b0}
            + (mq_r[apm_pkg::OUT_W-1] ? apm_pkg::POW_W'(vmv_r) : '0);
    sq_nxt  = {sq_r[apm_pkg::POW_W-2:0], 1'b0}
            + (mq_r[apm_pkg::OUT_W-1] ? apm_pkg::POW_W'(cma_r) : '0);

    sum_add   = sq_sum_r + apm_pkg::SUM_W'(sq_nxt);
    cnt_inc   = win_cnt_r + apm_pkg::LEN_W'(1);
    win_close = (cnt_inc >= len_eff) || (cnt_inc == '0);

    div_sh     = {dv_rem_r, dq_r[apm_pkg::SUM_W-1]};
    div_ge     = (div_sh >= {1'b0, len_eff});
    dv_rem_nxt = div_ge ? apm_pkg::LEN_W'(div_sh - {1'b0, len_eff})
                        : div_sh[apm_pkg::LEN_W-1:0];
    dq_nxt     = {dq_r[apm_pkg::SUM_W-2:0], div_ge};
    rad_ld     = (|dq_nxt[apm_pkg::SUM_W-1:apm_pkg::POW_W]) ? '1
                                                            : dq_nxt[apm_pkg::POW_W-1:0];

    sq_cur   = {srem_r, rad_r[apm_pkg::POW_W-1:apm_pkg::POW_W-2]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_ge    = (sq_cur >= sq_trial);
    srem_nxt = sq_ge ? (apm_pkg::OUT_W+1)'(sq_cur - sq_trial)
                     : sq_cur[apm_pkg::OUT_W:0];
    root_nxt = {root_r[apm_pkg::OUT_W-2:0], sq_ge};
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_voltage_mv = out_vmv_r;
  assign out_current_ma = out_cma_r;
  assign out_power_uw   = out_pow_r;
  assign out_rms_ma     = out_rms_r;
  assign out_rms_valid  = out_rmsv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vgain_r     <= apm_pkg::VOLTAGE_GAIN_RST;
      cgain_r     <= apm_pkg::CURRENT_GAIN_RST;
      len_r       <= apm_pkg::WINDOW_LENGTH_RST;
      win_cnt_r   <= '0;
      sq_sum_r    <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          apm_pkg::REG_VOLTAGE_GAIN:  vgain_r <= cfg_data;
          apm_pkg::REG_CURRENT_GAIN:  cgain_r <= cfg_data;
          apm_pkg::REG_WINDOW_LENGTH: len_r   <= cfg_data[apm_pkg::LEN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            vs_r    <= apm_pkg::ADC_BITS'(in_voltage_sample);
            cs_r    <= apm_pkg::ADC_BITS'(in_current_sample);
            acc_v_r <= '0;
            acc_c_r <= '0;
            step_r  <= apm_pkg::CNT_W'(apm_pkg::ADC_BITS - 1);
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          acc_v_r <= acc_v_nxt;
          acc_c_r <= acc_c_nxt;
          vs_r    <= {vs_r[apm_pkg::ADC_BITS-2:0], 1'b0};
          cs_r    <= {cs_r[apm_pkg::ADC_BITS-2:0], 1'b0};
          if (step_last) begin
            vmv_r   <= apm_pkg::sat_scale(acc_v_nxt);
            cma_r   <= apm_pkg::sat_scale(acc_c_nxt);
            mq_r    <= apm_pkg::sat_scale(acc_c_nxt);
            pow_r   <= '0;
            sq_r    <= '0;
            step_r  <= apm_pkg::CNT_W'(apm_pkg::OUT_W - 1);
            state_r <= ST_MULT;
          end else begin
            step_r  <= step_r - apm_pkg::CNT_W'(1);
          end
        end
        ST_MULT: begin
          pow_r  <= pow_nxt;
          sq_r   <= sq_nxt;
          mq_r   <= {mq_r[apm_pkg::OUT_W-2:0], 1'b0};
          if (step_last) begin
            if (win_close) begin
              sq_sum_r  <= '0;
              win_cnt_r <= '0;
              dq_r      <= sum_add;
              dv_rem_r  <= '0;
              step_r    <= apm_pkg::CNT_W'(apm_pkg::SUM_W - 1);
              state_r   <= ST_DIV;
            end else begin
              sq_sum_r  <= sum_add;
              win_cnt_r <= cnt_inc;
              root_r    <= '0;
              rmsv_r    <= 1'b0;
              state_r   <= ST_DONE;
            end
          end else begin
            step_r <= step_r - apm_pkg::CNT_W'(1);
          end
        end
        ST_DIV: begin
          dq_r     <= dq_nxt;
          dv_rem_r <= dv_rem_nxt;
          if (step_last) begin
            rad_r   <= rad_ld;
            srem_r  <= '0;
            root_r  <= '0;
            step_r  <= apm_pkg::CNT_W'(apm_pkg::OUT_W - 1);
            state_r <= ST_SQRT;
          end else begin
            step_r  <= step_r - apm_pkg::CNT_W'(1);
          end
        end
        ST_SQRT: begin
          rad_r  <= {rad_r[apm_pkg::POW_W-3:0], 2'b00};
          srem_r <= srem_nxt;
          root_r <= root_nxt;
          step_r <= step_r - apm_pkg::CNT_W'(1);
          if (step_last) begin
            rmsv_r  <= 1'b1;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_vmv_r   <= vmv_r;
            out_cma_r   <= cma_r;
            out_pow_r   <= pow_r;
            out_rms_r   <= root_r;
            out_rmsv_r  <= rmsv_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_rms_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rmsv_r || out_rms_r == '0))
    else $error("rms_ma nonzero without rms_valid");

  a_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pow_r == apm_pkg::POW_W'(out_vmv_r) * apm_pkg::POW_W'(out_cma_r)))
    else $error("power differs from voltage times current");

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
    (win_cnt_r == '0) |-> (sq_sum_r == '0))
    else $error("square sum held with empty window");
`endif

endmodule
